FILE: hdl/lgos_pkg.sv
// Shared types, widths, constants and helpers of the lane gap obstacle scanner.
// No dependencies; compiled first.
`default_nettype none

package lgos_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned EDGE_W     = 14;
  localparam int unsigned BRIGHT_W   = 10;
  localparam int unsigned DARK_W     = 11;
  localparam int unsigned SUM4_W     = 10;
  localparam int unsigned SUM5_W     = 11;
  localparam int unsigned HIST_DEPTH = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // columns at or above this are never scanned
  localparam int unsigned MAX_LINE = 1024;

  localparam logic [EDGE_W-1:0] NO_HIT      = EDGE_W'(9999);
  localparam logic [COL_W-1:0]  EDGE_OFFSET = COL_W'(5);

  localparam logic [ROW_W-1:0]    ROW_START_RST = ROW_W'(130);
  localparam logic [ROW_W-1:0]    ROW_STOP_RST  = ROW_W'(90);
  localparam logic [COL_W-1:0]    COL_START_RST = COL_W'(220);
  localparam logic [COL_W-1:0]    COL_STOP_RST  = COL_W'(20);
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST    = BRIGHT_W'(80);
  localparam logic [DARK_W-1:0]   DARK_RST      = DARK_W'(20);

  typedef enum logic [1:0] {
    PH_RIGHT = 2'd0,
    PH_GAP   = 2'd1,
    PH_LEFT  = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_START = 3'd0,
    CFG_ROW_STOP  = 3'd1,
    CFG_COL_START = 3'd2,
    CFG_COL_STOP  = 3'd3,
    CFG_BRIGHT    = 3'd4,
    CFG_DARK      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ROW_W-1:0]    row_start;
    logic [ROW_W-1:0]    row_stop;
    logic [COL_W-1:0]    col_start;
    logic [COL_W-1:0]    col_stop;
    logic [BRIGHT_W-1:0] bright_thr;
    logic [DARK_W-1:0]   dark_thr;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last_in_frame;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [EDGE_W-1:0] right_edge;
    logic [EDGE_W-1:0] left_edge;
    logic [ROW_W-1:0]  hit_row;
  } result_t;

  // column minus offset, saturating at zero
  function automatic logic [EDGE_W-1:0] edge_of(input logic [COL_W-1:0] col);
    logic [COL_W-1:0] diff;
    diff = col - EDGE_OFFSET;
    return (col >= EDGE_OFFSET) ? EDGE_W'(diff) : '0;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lgos_if.sv
// Valid/ready channel interfaces for the pixel input and the result output.
// Depends on lgos_pkg for field widths.
`default_nettype none

interface lgos_in_if;
  logic                          valid;
  logic                          ready;
  logic [lgos_pkg::PIX_W-1:0]    pixel;
  logic [lgos_pkg::COL_W-1:0]    column;
  logic [lgos_pkg::ROW_W-1:0]    row;
  logic                          last_in_frame;

  modport source (output valid, output pixel, output column, output row,
                  output last_in_frame, input ready);
  modport sink   (input valid, input pixel, input column, input row,
                  input last_in_frame, output ready);
endinterface

interface lgos_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [lgos_pkg::EDGE_W-1:0]   right_edge;
  logic [lgos_pkg::EDGE_W-1:0]   left_edge;
  logic [lgos_pkg::ROW_W-1:0]    hit_row;

  modport source (output valid, output found, output right_edge, output left_edge,
                  output hit_row, input ready);
  modport sink   (input valid, input found, input right_edge, input left_edge,
                  input hit_row, output ready);
endinterface

`default_nettype wire

FILE: hdl/lgos_scan.sv
// Scan core: pixel history, three-phase gap search and frame bookkeeping.
// Depends on lgos_pkg.
`default_nettype none

module lgos_scan (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire lgos_pkg::item_t   item_i,
  input  wire lgos_pkg::cfg_t    cfg_i,
  output logic                   emit_o,
  output lgos_pkg::result_t      result_o
);
  import lgos_pkg::*;

  logic [PIX_W-1:0] hist_q [HIST_DEPTH];
  logic [PIX_W-1:0] hist_d [HIST_DEPTH];
  phase_e           phase_q, phase_d, phase_eff;
  logic [COL_W-1:0] hold_q, hold_d;
  logic             done_q, done_d;

  logic [SUM4_W-1:0] sum4;
  logic [SUM5_W-1:0] sum5;
  logic              in_rows, in_cols, scan, bright, dark, hit;

  assign sum4 = SUM4_W'(item_i.pixel) + SUM4_W'(hist_q[0])
              + SUM4_W'(hist_q[1]) + SUM4_W'(hist_q[2]);
  assign sum5 = SUM5_W'(sum4) + SUM5_W'(hist_q[3]);

  assign in_rows = (item_i.row <= cfg_i.row_start) && (item_i.row > cfg_i.row_stop);
  assign in_cols = (item_i.column <= cfg_i.col_start) && (item_i.column > cfg_i.col_stop)
                && (32'(item_i.column) < MAX_LINE);
  assign scan    = !done_q && in_rows && in_cols;

  assign bright = sum4 > cfg_i.bright_thr;
  assign dark   = sum5 < cfg_i.dark_thr;

  // row restart at col_start; spare code behaves as right-line search
  always_comb begin
    if ((item_i.column == cfg_i.col_start) ||
        ((phase_q != PH_GAP) && (phase_q != PH_LEFT))) begin
      phase_eff = PH_RIGHT;
    end else begin
      phase_eff = phase_q;
    end
  end

  assign hit = scan && (phase_eff == PH_LEFT) && bright;

  // next state
  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_q;
    done_d  = done_q;
    if (scan) begin
      case (phase_eff)
        PH_RIGHT: begin
          phase_d = bright ? PH_GAP : PH_RIGHT;
          if (bright) hold_d = item_i.column;
        end
        PH_GAP: begin
          phase_d = dark ? PH_LEFT : PH_GAP;
        end
        PH_LEFT: begin
          phase_d = PH_LEFT;
          if (bright) done_d = 1'b1;
        end
        default: begin
          phase_d = PH_RIGHT;
        end
      endcase
    end
    hist_d[0] = item_i.pixel;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      hist_d[i] = hist_q[i-1];
    end
    if (item_i.last_in_frame) begin
      phase_d = PH_RIGHT;
      hold_d  = '0;
      done_d  = 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_d[i] = '0;
      end
    end
  end

  // outputs: a match, or the not-found result at frame end
  always_comb begin
    emit_o = hit || (item_i.last_in_frame && !done_q);
    if (hit) begin
      result_o.found      = 1'b1;
      result_o.right_edge = edge_of(hold_q);
      result_o.left_edge  = edge_of(item_i.column);
      result_o.hit_row    = item_i.row;
    end else begin
      result_o.found      = 1'b0;
      result_o.right_edge = NO_HIT;
      result_o.left_edge  = NO_HIT;
      result_o.hit_row    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIGHT;
      hold_q  <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (step_i) begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      done_q  <= done_d;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_q[i] <= hist_d[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lane_gap_obstacle_scanner_top.sv
// Top level of the lane gap obstacle scanner: config registers, input register,
// result register and handshakes. Depends on lgos_pkg, lgos_if and lgos_scan.
//
// Usage:
//   in_chan_i carries one mask pixel per request with its column, row and an
//   end-of-frame flag; rows come right to left, bottom to top.
//   res_chan_o carries at most one result per frame: the first gap match, or a
//   not-found result (both edges 9999, row 0) on the frame's last pixel.
//   Config registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i,
//   one per cycle; the user must write them only while no request is in
//   flight (the block does not enforce this); unknown indexes are ignored.
// Timing:
//   One pixel per clock sustained, except while a result waits as below. A
//   request is held in the input register, is scanned there, and its result
//   is captured in the result register, which drives res_chan_o.
//   When the receiver stalls, pixels that produce no result keep flowing; a
//   pixel that produces a result waits in the input register until the result
//   register frees, and in_chan_i.ready drops only then.
// Reset:
//   Clears history, phase and frame status, loads default config registers
//   (rows 130..91, columns 220..21, bright 80, dark 20) and empties both
//   stages.
`default_nettype none

module lane_gap_obstacle_scanner_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  lgos_in_if.sink                            in_chan_i,
  lgos_out_if.source                         res_chan_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [lgos_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lgos_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lgos_pkg::*;

  cfg_t    cfg_q;
  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_res_q;

  logic    emit;
  result_t scan_res;
  logic    out_free, s1_adv, in_ready, in_take;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_start  <= ROW_START_RST;
      cfg_q.row_stop   <= ROW_STOP_RST;
      cfg_q.col_start  <= COL_START_RST;
      cfg_q.col_stop   <= COL_STOP_RST;
      cfg_q.bright_thr <= BRIGHT_RST;
      cfg_q.dark_thr   <= DARK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_START: cfg_q.row_start  <= cfg_wdata_i[ROW_W-1:0];
        CFG_ROW_STOP:  cfg_q.row_stop   <= cfg_wdata_i[ROW_W-1:0];
        CFG_COL_START: cfg_q.col_start  <= cfg_wdata_i[COL_W-1:0];
        CFG_COL_STOP:  cfg_q.col_stop   <= cfg_wdata_i[COL_W-1:0];
        CFG_BRIGHT:    cfg_q.bright_thr <= cfg_wdata_i[BRIGHT_W-1:0];
        CFG_DARK:      cfg_q.dark_thr   <= cfg_wdata_i[DARK_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || res_chan_o.ready;
  assign s1_adv   = s1_valid_q && (!emit || out_free);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_take  = in_chan_i.valid && in_ready;

  assign in_chan_i.ready = in_ready;

  lgos_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .emit_o   (emit),
    .result_o (scan_res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.pixel         <= in_chan_i.pixel;
      s1_item_q.column        <= in_chan_i.column;
      s1_item_q.row           <= in_chan_i.row;
      s1_item_q.last_in_frame <= in_chan_i.last_in_frame;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (res_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_res_q <= scan_res;
    end
  end

  assign res_chan_o.valid      = out_valid_q;
  assign res_chan_o.found      = out_res_q.found;
  assign res_chan_o.right_edge = out_res_q.right_edge;
  assign res_chan_o.left_edge  = out_res_q.left_edge;
  assign res_chan_o.hit_row    = out_res_q.hit_row;

endmodule

`default_nettype wire
